// File: sv/idps_pkg.sv
package idps_pkg;

   // Field widths fixed by the interface
   localparam int TIME_W   = 16;
   localparam int OP_W     = 3;
   localparam int STAGE_W  = 2;
   localparam int EVENT_W  = 3;
   localparam int CVAL_W   = 4;
   localparam int MODE_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Default parameter values
   localparam int SHORT_PERIOD_MS_DEF  = 100;
   localparam int SECOND_PERIOD_MS_DEF = 1000;
   localparam int SAVER_IDLE_LIMIT_DEF = 9000;
   localparam int COUNTDOWN_START_DEF  = 10;

   // Register reset values
   localparam logic [TIME_W-1:0] DEMO_WAIT_LIMIT_RST  = 16'd3000;
   localparam logic [TIME_W-1:0] SET_TIME_CEILING_RST = 16'd9000;
   localparam logic              SAVER_ENABLE_RST     = 1'b1;

   localparam logic [TIME_W-1:0] TIME_MAX = 16'hFFFF;

   typedef enum logic [OP_W-1:0] {
      OP_TICK    = 3'd0,
      OP_PROCESS = 3'd1,
      OP_CLEAR   = 3'd2,
      OP_SET     = 3'd3,
      OP_QUICK   = 3'd4
   } op_type;

   localparam logic [STAGE_W-1:0] STAGE_USER = 2'd0;
   localparam logic [STAGE_W-1:0] STAGE_ENGR = 2'd1;

   typedef enum logic [MODE_W-1:0] {
      MODE_IDLE  = 2'd0,
      MODE_DEMO  = 2'd1,
      MODE_COUNT = 2'd2,
      MODE_LOW   = 2'd3
   } mode_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE       = 3'd0,
      EV_STEP       = 3'd1,
      EV_DEMO       = 3'd2,
      EV_QUIT_DEMO  = 3'd3,
      EV_QUIT_COUNT = 3'd4,
      EV_LOW        = 3'd5
   } event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEMO_WAIT_LIMIT  = 2'd0,
      CSR_SET_TIME_CEILING = 2'd1,
      CSR_SAVER_ENABLE     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [TIME_W-1:0] demo_wait_limit;
      logic [TIME_W-1:0] set_time_ceiling;
      logic              saver_enable;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [STAGE_W-1:0] stage_class;
      logic               key_pressed;
      logic [TIME_W-1:0]  time_value;
   } req_item_type;

   typedef struct packed {
      logic [EVENT_W-1:0] event_kind;
      logic [CVAL_W-1:0]  countdown_value;
      logic [MODE_W-1:0]  mode_state;
   } rsp_item_type;

   // Timebase controls from the mode unit
   typedef struct packed {
      logic tick;
      logic short_flag_clr;
      logic second_flag_clr;
      logic second_count_clr;
   } tb_ctl_type;

   typedef struct packed {
      logic short_flag;
      logic second_flag;
   } tb_flags_type;

endpackage

// File: sv/idps_timebase.sv
module idps_timebase #(
   parameter int SHORT_PERIOD_MS  = idps_pkg::SHORT_PERIOD_MS_DEF,
   parameter int SECOND_PERIOD_MS = idps_pkg::SECOND_PERIOD_MS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  idps_pkg::tb_ctl_type   ctl,
   output idps_pkg::tb_flags_type flags
);

   localparam int SHORT_W  = $clog2(SHORT_PERIOD_MS + 1);
   localparam int SECOND_W = $clog2(SECOND_PERIOD_MS + 1);

   logic [SHORT_W-1:0]  short_count_ff, short_count_in, short_inc;
   logic [SECOND_W-1:0] second_count_ff, second_count_in, second_inc;
   logic                short_flag_ff, short_flag_in;
   logic                second_flag_ff, second_flag_in;

   assign short_inc  = short_count_ff + 1'b1;
   assign second_inc = second_count_ff + 1'b1;

   // 100 ms divider
   always_comb begin
      short_count_in = short_count_ff;
      short_flag_in  = short_flag_ff;
      if (ctl.tick) begin
         if (short_inc >= SHORT_W'(SHORT_PERIOD_MS)) begin
            short_count_in = '0;
            short_flag_in  = 1'b1;
         end else begin
            short_count_in = short_inc;
         end
      end else if (ctl.short_flag_clr) begin
         short_flag_in = 1'b0;
      end
   end

   // 1 s divider; the mode unit may restart it
   always_comb begin
      second_count_in = second_count_ff;
      second_flag_in  = second_flag_ff;
      if (ctl.tick) begin
         if (second_inc >= SECOND_W'(SECOND_PERIOD_MS)) begin
            second_count_in = '0;
            second_flag_in  = 1'b1;
         end else begin
            second_count_in = second_inc;
         end
      end else begin
         if (ctl.second_count_clr) begin
            second_count_in = '0;
         end
         if (ctl.second_flag_clr) begin
            second_flag_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_count_ff  <= '0;
         second_count_ff <= '0;
         short_flag_ff   <= 1'b0;
         second_flag_ff  <= 1'b0;
      end else begin
         short_count_ff  <= short_count_in;
         second_count_ff <= second_count_in;
         short_flag_ff   <= short_flag_in;
         second_flag_ff  <= second_flag_in;
      end
   end

   assign flags.short_flag  = short_flag_ff;
   assign flags.second_flag = second_flag_ff;

endmodule

// File: sv/idps_mode_unit.sv
module idps_mode_unit #(
   parameter int SAVER_IDLE_LIMIT = idps_pkg::SAVER_IDLE_LIMIT_DEF,
   parameter int COUNTDOWN_START  = idps_pkg::COUNTDOWN_START_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  idps_pkg::req_item_type item,
   input  idps_pkg::cfg_type      cfg,
   input  idps_pkg::tb_flags_type flags,
   output idps_pkg::tb_ctl_type   tb_ctl,
   output idps_pkg::rsp_item_type result
);

   localparam logic [idps_pkg::TIME_W-1:0] SAVER_LIM = idps_pkg::TIME_W'(SAVER_IDLE_LIMIT);
   localparam logic [idps_pkg::CVAL_W-1:0] CD_START  = idps_pkg::CVAL_W'(COUNTDOWN_START);

   idps_pkg::mode_type             mode_ff, mode_in;
   logic [idps_pkg::TIME_W-1:0]    idle_time_ff, idle_time_in;
   logic [idps_pkg::CVAL_W-1:0]    countdown_ff, countdown_in;
   idps_pkg::event_type            event_kind;
   logic [idps_pkg::CVAL_W-1:0]    cval;
   idps_pkg::tb_ctl_type           ctl;

   // Shared decode
   logic                           blocked;
   logic [idps_pkg::TIME_W-1:0]    idle_eff;
   logic [idps_pkg::TIME_W-1:0]    idle_bump;
   logic                           saver_due;
   logic                           demo_due;
   logic                           cd_more;

   // engineering stage counts as user once past the demo limit
   assign blocked  = (item.stage_class != idps_pkg::STAGE_USER) &&
                     !((item.stage_class == idps_pkg::STAGE_ENGR) &&
                       (idle_time_ff > cfg.demo_wait_limit));
   // a key in idle clears the timer before the flag is looked at
   assign idle_eff = (mode_ff == idps_pkg::MODE_IDLE && item.key_pressed) ? '0 : idle_time_ff;
   assign idle_bump = (idle_eff == idps_pkg::TIME_MAX) ? idle_eff : idle_eff + 1'b1;
   assign saver_due = (idle_eff >= SAVER_LIM) && cfg.saver_enable;
   assign demo_due  = (idle_eff >= cfg.demo_wait_limit);
   assign cd_more   = (countdown_ff > idps_pkg::CVAL_W'(1));

   // Next mode
   always_comb begin
      mode_in = mode_ff;
      case (idps_pkg::op_type'(item.op))
         idps_pkg::OP_CLEAR: begin
            mode_in = idps_pkg::MODE_IDLE;
         end
         idps_pkg::OP_PROCESS: begin
            if (blocked) begin
               mode_in = idps_pkg::MODE_IDLE;
            end else begin
               case (mode_ff)
                  idps_pkg::MODE_IDLE: begin
                     if (flags.short_flag) begin
                        if (saver_due) begin
                           mode_in = idps_pkg::MODE_COUNT;
                        end else if (demo_due) begin
                           mode_in = idps_pkg::MODE_DEMO;
                        end
                     end
                  end
                  idps_pkg::MODE_DEMO: begin
                     if (item.key_pressed) begin
                        mode_in = idps_pkg::MODE_IDLE;
                     end else if (flags.short_flag && saver_due) begin
                        mode_in = idps_pkg::MODE_COUNT;
                     end
                  end
                  idps_pkg::MODE_COUNT: begin
                     if (item.key_pressed) begin
                        mode_in = idps_pkg::MODE_IDLE;
                     end else if (flags.second_flag && !cd_more) begin
                        mode_in = idps_pkg::MODE_LOW;
                     end
                  end
                  default: begin
                     mode_in = idps_pkg::MODE_IDLE;
                  end
               endcase
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   // Timer, countdown, events and timebase controls
   always_comb begin
      idle_time_in = idle_time_ff;
      countdown_in = countdown_ff;
      event_kind   = idps_pkg::EV_NONE;
      cval         = '0;
      ctl          = '0;
      case (idps_pkg::op_type'(item.op))
         idps_pkg::OP_TICK: begin
            ctl.tick = 1'b1;
         end
         idps_pkg::OP_CLEAR: begin
            idle_time_in = '0;
         end
         idps_pkg::OP_SET: begin
            idle_time_in = (item.time_value >= cfg.set_time_ceiling) ?
                           cfg.set_time_ceiling : item.time_value;
         end
         idps_pkg::OP_QUICK: begin
            idle_time_in = SAVER_LIM;
         end
         idps_pkg::OP_PROCESS: begin
            if (blocked) begin
               idle_time_in = '0;
            end else begin
               case (mode_ff)
                  idps_pkg::MODE_IDLE: begin
                     idle_time_in = idle_eff;
                     if (flags.short_flag) begin
                        ctl.short_flag_clr = 1'b1;
                        if (saver_due) begin
                           ctl.second_flag_clr  = 1'b1;
                           ctl.second_count_clr = 1'b1;
                           event_kind = idps_pkg::EV_STEP;
                           cval       = countdown_ff;
                        end else if (demo_due) begin
                           event_kind = idps_pkg::EV_DEMO;
                        end else begin
                           idle_time_in = idle_bump;
                        end
                     end
                  end
                  idps_pkg::MODE_DEMO: begin
                     if (item.key_pressed) begin
                        idle_time_in       = '0;
                        ctl.short_flag_clr = 1'b1;
                        event_kind         = idps_pkg::EV_QUIT_DEMO;
                     end else if (flags.short_flag) begin
                        ctl.short_flag_clr = 1'b1;
                        if (saver_due) begin
                           ctl.second_flag_clr  = 1'b1;
                           ctl.second_count_clr = 1'b1;
                           event_kind = idps_pkg::EV_STEP;
                           cval       = countdown_ff;
                        end else begin
                           idle_time_in = idle_bump;
                        end
                     end
                  end
                  idps_pkg::MODE_COUNT: begin
                     if (item.key_pressed) begin
                        ctl.second_flag_clr = 1'b1;
                        countdown_in        = CD_START;
                        idle_time_in        = '0;
                        event_kind          = idps_pkg::EV_QUIT_COUNT;
                     end else if (flags.second_flag) begin
                        ctl.second_flag_clr  = 1'b1;
                        ctl.second_count_clr = 1'b1;
                        if (cd_more) begin
                           countdown_in = countdown_ff - 1'b1;
                           event_kind   = idps_pkg::EV_STEP;
                           cval         = countdown_ff - 1'b1;
                        end else begin
                           event_kind = idps_pkg::EV_LOW;
                        end
                     end
                  end
                  default: begin
                     // wake-up from low power
                     idle_time_in         = '0;
                     countdown_in         = CD_START;
                     ctl.second_flag_clr  = 1'b1;
                     ctl.second_count_clr = 1'b1;
                  end
               endcase
            end
         end
         default: begin
            idle_time_in = idle_time_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= idps_pkg::MODE_IDLE;
         idle_time_ff <= '0;
         countdown_ff <= CD_START;
      end else if (advance) begin
         mode_ff      <= mode_in;
         idle_time_ff <= idle_time_in;
         countdown_ff <= countdown_in;
      end
   end

   assign tb_ctl.tick             = advance && ctl.tick;
   assign tb_ctl.short_flag_clr   = advance && ctl.short_flag_clr;
   assign tb_ctl.second_flag_clr  = advance && ctl.second_flag_clr;
   assign tb_ctl.second_count_clr = advance && ctl.second_count_clr;

   assign result.event_kind      = event_kind;
   assign result.countdown_value = cval;
   assign result.mode_state      = mode_in;

endmodule

// File: sv/idle_power_down_sequencer_core.sv
// An accepted request item passes the input register, then the result register,
// to become its response item; the mode unit settles each item in a single pass.
// Throughput: one item per cycle while the response channel is not stalled.
// Reset (synchronous, active high) empties both registers, returns to idle
// with timer and dividers cleared and the countdown reloaded, and restores
// the register defaults.
module idle_power_down_sequencer_core #(
   parameter int SHORT_PERIOD_MS  = idps_pkg::SHORT_PERIOD_MS_DEF,
   parameter int SECOND_PERIOD_MS = idps_pkg::SECOND_PERIOD_MS_DEF,
   parameter int SAVER_IDLE_LIMIT = idps_pkg::SAVER_IDLE_LIMIT_DEF,
   parameter int COUNTDOWN_START  = idps_pkg::COUNTDOWN_START_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [idps_pkg::OP_W-1:0]         req_op,
   input  logic [idps_pkg::STAGE_W-1:0]      req_stage_class,
   input  logic                              req_key_pressed,
   input  logic [idps_pkg::TIME_W-1:0]       req_time_value,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [idps_pkg::EVENT_W-1:0]      rsp_event_kind,
   output logic [idps_pkg::CVAL_W-1:0]       rsp_countdown_value,
   output logic [idps_pkg::MODE_W-1:0]       rsp_mode_state,
   // configuration
   input  logic                              csr_we,
   input  logic [idps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [idps_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic                   in_valid_ff;
   idps_pkg::req_item_type in_item_ff;
   logic                   out_valid_ff;
   idps_pkg::rsp_item_type out_item_ff;
   logic                   advance;
   logic                   req_take;
   idps_pkg::cfg_type      cfg_ff;
   idps_pkg::tb_ctl_type   tb_ctl;
   idps_pkg::tb_flags_type tb_flags;
   idps_pkg::rsp_item_type result;

   // Handshake: the item in the input register moves on when the result slot frees
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.demo_wait_limit  <= idps_pkg::DEMO_WAIT_LIMIT_RST;
         cfg_ff.set_time_ceiling <= idps_pkg::SET_TIME_CEILING_RST;
         cfg_ff.saver_enable     <= idps_pkg::SAVER_ENABLE_RST;
      end else if (csr_we) begin
         case (idps_pkg::csr_index_type'(csr_index))
            idps_pkg::CSR_DEMO_WAIT_LIMIT:  cfg_ff.demo_wait_limit  <= csr_wdata;
            idps_pkg::CSR_SET_TIME_CEILING: cfg_ff.set_time_ceiling <= csr_wdata;
            idps_pkg::CSR_SAVER_ENABLE:     cfg_ff.saver_enable     <= csr_wdata[0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.op          <= req_op;
         in_item_ff.stage_class <= req_stage_class;
         in_item_ff.key_pressed <= req_key_pressed;
         in_item_ff.time_value  <= req_time_value;
      end
   end

   idps_timebase #(
      .SHORT_PERIOD_MS  (SHORT_PERIOD_MS),
      .SECOND_PERIOD_MS (SECOND_PERIOD_MS)
   ) u_timebase (
      .clock (clock),
      .reset (reset),
      .ctl   (tb_ctl),
      .flags (tb_flags)
   );

   idps_mode_unit #(
      .SAVER_IDLE_LIMIT (SAVER_IDLE_LIMIT),
      .COUNTDOWN_START  (COUNTDOWN_START)
   ) u_mode (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .flags   (tb_flags),
      .tb_ctl  (tb_ctl),
      .result  (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_event_kind      = out_item_ff.event_kind;
   assign rsp_countdown_value = out_item_ff.countdown_value;
   assign rsp_mode_state      = out_item_ff.mode_state;

endmodule

// File: sv/idps_checker.sv
module idps_port_props (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [idps_pkg::EVENT_W-1:0] rsp_event_kind,
   input logic [idps_pkg::CVAL_W-1:0]  rsp_countdown_value,
   input logic [idps_pkg::MODE_W-1:0]  rsp_mode_state
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_kind) &&
         $stable(rsp_countdown_value) && $stable(rsp_mode_state))
      else $error("stalled response changed");

   // countdown value only on step events, and never zero there
   a_cval: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_event_kind == idps_pkg::EV_STEP) ==
                     (rsp_countdown_value != '0)))
      else $error("countdown value mismatch with event");

   // events agree with the reported mode
   a_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_event_kind != idps_pkg::EV_STEP  || rsp_mode_state == idps_pkg::MODE_COUNT) &&
         (rsp_event_kind != idps_pkg::EV_DEMO  || rsp_mode_state == idps_pkg::MODE_DEMO) &&
         (rsp_event_kind != idps_pkg::EV_LOW   || rsp_mode_state == idps_pkg::MODE_LOW) &&
         (rsp_event_kind != idps_pkg::EV_QUIT_DEMO  ||
          rsp_mode_state == idps_pkg::MODE_IDLE) &&
         (rsp_event_kind != idps_pkg::EV_QUIT_COUNT ||
          rsp_mode_state == idps_pkg::MODE_IDLE))
      else $error("event and mode disagree");

   // reset empties the response register
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind idle_power_down_sequencer_core idps_port_props u_idps_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_event_kind      (rsp_event_kind),
   .rsp_countdown_value (rsp_countdown_value),
   .rsp_mode_state      (rsp_mode_state)
);
